### rtl/killer_move_table_reorder_macros.svh
// Assertion macros used by the top RTL file of the killer move table.
`ifndef KILLER_MOVE_TABLE_REORDER_MACROS_SVH
`define KILLER_MOVE_TABLE_REORDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KMTR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define KMTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KMTR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define KMTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/kmtr_pkg.sv
`timescale 1ns / 1ps
package kmtr_pkg;

   localparam int ACTION_W    = 2;
   localparam int DEPTH_W     = 6;
   localparam int POS_W       = 6;
   localparam int WORD_W      = 32;
   localparam int IDX_W       = POS_W + 1;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SAVE    = 2'd0,
      ACT_LOAD    = 2'd1,
      ACT_REORDER = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAVE,
      ST_SEARCH,
      ST_SHIFT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      action_type          action;
      logic                depth_ok;
      logic [DEPTH_W-1:0]  depth;
      logic [POS_W-1:0]    position;
      logic [WORD_W-1:0]   move_code;
      logic [WORD_W-1:0]   score;
      logic                last;
   } cmd_type;

endpackage

### rtl/kmtr_front.sv
`timescale 1ns / 1ps
module kmtr_front #(
   parameter int DEPTH_LEVELS = 64
) (
   input  logic                                start,
   input  logic                                queue_full,
   input  logic [kmtr_pkg::ACTION_W-1:0]       req_action,
   input  logic [kmtr_pkg::DEPTH_W-1:0]        req_depth,
   input  logic [kmtr_pkg::POS_W-1:0]          req_position,
   input  logic signed [kmtr_pkg::WORD_W-1:0]  req_move_code,
   input  logic signed [kmtr_pkg::WORD_W-1:0]  req_score,
   input  logic                                req_last,
   output logic                                push,
   output kmtr_pkg::cmd_type                   cmd
);

   // A request is decoded and its depth range-checked before it enters the queue.
   always_comb begin
      push          = start && !queue_full;
      cmd.action    = kmtr_pkg::action_type'(req_action);
      cmd.depth_ok  = (32'(req_depth) < DEPTH_LEVELS);
      cmd.depth     = req_depth;
      cmd.position  = req_position;
      cmd.move_code = req_move_code;
      cmd.score     = req_score;
      cmd.last      = req_last;
   end

endmodule

### rtl/kmtr_queue.sv
`timescale 1ns / 1ps
module kmtr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kmtr_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output kmtr_pkg::cmd_type head_cmd
);

   localparam int QA = (kmtr_pkg::QUEUE_DEPTH > 1) ? $clog2(kmtr_pkg::QUEUE_DEPTH) : 1;
   localparam int QC = $clog2(kmtr_pkg::QUEUE_DEPTH + 1);

   kmtr_pkg::cmd_type entry_ff [kmtr_pkg::QUEUE_DEPTH];
   logic [QA-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      full       = (count_ff == QC'(kmtr_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = entry_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QA'(kmtr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QA'(kmtr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/kmtr_back.sv
`timescale 1ns / 1ps
module kmtr_back #(
   parameter int DEPTH_LEVELS = 64,
   parameter int LIST_SIZE    = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  kmtr_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   output logic signed [kmtr_pkg::WORD_W-1:0]  rsp_out_move,
   output logic signed [kmtr_pkg::WORD_W-1:0]  rsp_out_score,
   output logic [kmtr_pkg::POS_W-1:0]          rsp_out_index,
   output logic                                rsp_out_last
);

   localparam int W   = kmtr_pkg::WORD_W;
   localparam int IW  = kmtr_pkg::IDX_W;
   localparam int KA  = (DEPTH_LEVELS > 1) ? $clog2(DEPTH_LEVELS) : 1;
   localparam int LA  = $clog2(LIST_SIZE);
   localparam int CW  = $clog2(LIST_SIZE + 1);

   kmtr_pkg::state_type state_ff, state_in;
   kmtr_pkg::cmd_type   cmd_ff, cmd_in;

   logic [2*W-1:0] killer_mem [DEPTH_LEVELS];
   logic [2*W-1:0] list_mem [LIST_SIZE];

   logic [DEPTH_LEVELS-1:0] kvalid_ff, kvalid_in;
   logic [2*W-1:0]          krd_ff;
   logic                    krd_valid_ff;
   logic [2*W-1:0]          lrd_ff;

   logic [CW-1:0] list_length_ff, list_length_in;
   logic [CW-1:0] load_ptr_ff, load_ptr_in, load_ptr_next;
   logic          pass_ff, pass_in;
   logic          pend_ff, pend_in;
   logic          wpend_ff, wpend_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] issue_ff, issue_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic [IW-1:0] sh_ff, sh_in;
   logic [IW-1:0] wdst_ff, wdst_in;
   logic [2*W-1:0] hold_ff, hold_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [kmtr_pkg::POS_W-1:0] rsp_index_ff, rsp_index_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           km_we, km_re;
   logic [KA-1:0]  km_waddr, km_raddr;
   logic [2*W-1:0] km_wdata;
   logic           lm_we, lm_re;
   logic [LA-1:0]  lm_waddr, lm_raddr;
   logic [2*W-1:0] lm_wdata;

   logic [IW-1:0] len_ext;
   logic [IW-1:0] sh_dec;
   logic [W-1:0]  kfirst, ksecond, target, lrd_move;
   logic          search_hit, scan_more, shift_more, pass_end;

   always_comb begin
      len_ext    = IW'(list_length_ff);
      sh_dec     = sh_ff - IW'(1);
      kfirst     = krd_valid_ff ? krd_ff[2*W-1:W] : '0;
      ksecond    = krd_valid_ff ? krd_ff[W-1:0] : '0;
      target     = pass_ff ? ksecond : kfirst;
      lrd_move   = lrd_ff[2*W-1:W];
      search_hit = pend_ff && (lrd_move == target);
      scan_more  = (issue_ff < len_ext);
      shift_more = (sh_ff > start_ff);
      pass_end   = ((state_ff == kmtr_pkg::ST_SEARCH) && !search_hit && !scan_more) ||
                   ((state_ff == kmtr_pkg::ST_SHIFT) && !shift_more && !wpend_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmtr_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.action)
                  kmtr_pkg::ACT_SAVE:    state_in = kmtr_pkg::ST_SAVE;
                  kmtr_pkg::ACT_REORDER: state_in = cmd.depth_ok ? kmtr_pkg::ST_SEARCH
                                                                 : kmtr_pkg::ST_EMIT;
                  default:               state_in = kmtr_pkg::ST_IDLE;
               endcase
            end
         end
         kmtr_pkg::ST_SAVE: begin
            state_in = kmtr_pkg::ST_IDLE;
         end
         kmtr_pkg::ST_SEARCH: begin
            if (search_hit) begin
               state_in = kmtr_pkg::ST_SHIFT;
            end else if (pass_end) begin
               state_in = pass_ff ? kmtr_pkg::ST_EMIT : kmtr_pkg::ST_SEARCH;
            end
         end
         kmtr_pkg::ST_SHIFT: begin
            if (pass_end) begin
               state_in = pass_ff ? kmtr_pkg::ST_EMIT : kmtr_pkg::ST_SEARCH;
            end
         end
         kmtr_pkg::ST_EMIT: begin
            state_in = scan_more ? kmtr_pkg::ST_EMIT : kmtr_pkg::ST_IDLE;
         end
         default: begin
            state_in = kmtr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop        = 1'b0;
      cmd_in         = cmd_ff;
      km_we          = 1'b0;
      km_re          = 1'b0;
      km_waddr       = '0;
      km_raddr       = '0;
      km_wdata       = '0;
      lm_we          = 1'b0;
      lm_re          = 1'b0;
      lm_waddr       = '0;
      lm_raddr       = '0;
      lm_wdata       = '0;
      kvalid_in      = kvalid_ff;
      list_length_in = list_length_ff;
      load_ptr_in    = load_ptr_ff;
      load_ptr_next  = load_ptr_ff;
      pass_in        = pass_ff;
      pend_in        = pend_ff;
      wpend_in       = wpend_ff;
      start_in       = start_ff;
      issue_in       = issue_ff;
      pidx_in        = pidx_ff;
      sh_in          = sh_ff;
      wdst_in        = wdst_ff;
      hold_in        = hold_ff;
      rsp_valid_in   = 1'b0;
      rsp_index_in   = rsp_index_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         kmtr_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               case (cmd.action)
                  kmtr_pkg::ACT_SAVE: begin
                     if (cmd.depth_ok) begin
                        km_re    = 1'b1;
                        km_raddr = KA'(cmd.depth);
                     end
                     if (IW'(cmd.position) < len_ext) begin
                        lm_re    = 1'b1;
                        lm_raddr = LA'(cmd.position);
                     end
                  end
                  kmtr_pkg::ACT_LOAD: begin
                     if (load_ptr_ff < CW'(LIST_SIZE)) begin
                        lm_we         = 1'b1;
                        lm_waddr      = load_ptr_ff[LA-1:0];
                        lm_wdata      = {cmd.move_code, cmd.score};
                        load_ptr_next = load_ptr_ff + CW'(1);
                     end
                     load_ptr_in = load_ptr_next;
                     if (cmd.last) begin
                        list_length_in = load_ptr_next;
                        load_ptr_in    = '0;
                     end
                  end
                  kmtr_pkg::ACT_REORDER: begin
                     pend_in  = 1'b0;
                     pass_in  = 1'b0;
                     if (cmd.depth_ok) begin
                        km_re    = 1'b1;
                        km_raddr = KA'(cmd.depth);
                        start_in = IW'(cmd.position);
                        issue_in = IW'(cmd.position);
                     end else begin
                        issue_in = '0;
                     end
                  end
                  default: begin
                     kvalid_in = '0;
                  end
               endcase
            end
         end
         kmtr_pkg::ST_SAVE: begin
            if (cmd_ff.depth_ok && (IW'(cmd_ff.position) < len_ext) && (lrd_move != kfirst)) begin
               km_we                       = 1'b1;
               km_waddr                    = KA'(cmd_ff.depth);
               km_wdata                    = {lrd_move, kfirst};
               kvalid_in[KA'(cmd_ff.depth)] = 1'b1;
            end
         end
         kmtr_pkg::ST_SEARCH: begin
            if (search_hit) begin
               sh_in    = pidx_ff;
               hold_in  = lrd_ff;
               wpend_in = 1'b0;
               pend_in  = 1'b0;
            end else if (scan_more) begin
               lm_re    = 1'b1;
               lm_raddr = issue_ff[LA-1:0];
               pend_in  = 1'b1;
               pidx_in  = issue_ff;
               issue_in = issue_ff + IW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         kmtr_pkg::ST_SHIFT: begin
            if (wpend_ff) begin
               lm_we    = 1'b1;
               lm_waddr = wdst_ff[LA-1:0];
               lm_wdata = lrd_ff;
            end
            if (shift_more) begin
               lm_re    = 1'b1;
               lm_raddr = sh_dec[LA-1:0];
               wpend_in = 1'b1;
               wdst_in  = sh_ff;
               sh_in    = sh_dec;
            end else begin
               wpend_in = 1'b0;
               if (!wpend_ff) begin
                  lm_we    = 1'b1;
                  lm_waddr = start_ff[LA-1:0];
                  lm_wdata = hold_ff;
               end
            end
         end
         kmtr_pkg::ST_EMIT: begin
            if (scan_more) begin
               lm_re        = 1'b1;
               lm_raddr     = issue_ff[LA-1:0];
               rsp_valid_in = 1'b1;
               rsp_index_in = issue_ff[kmtr_pkg::POS_W-1:0];
               rsp_last_in  = ((issue_ff + IW'(1)) == len_ext);
               issue_in     = issue_ff + IW'(1);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase

      // The second killer is searched from one past the start of the first.
      if (pass_end) begin
         pend_in = 1'b0;
         if (!pass_ff) begin
            pass_in  = 1'b1;
            start_in = start_ff + IW'(1);
            issue_in = start_ff + IW'(1);
         end else begin
            issue_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= kmtr_pkg::ST_IDLE;
         kvalid_ff      <= '0;
         list_length_ff <= '0;
         load_ptr_ff    <= '0;
         pass_ff        <= 1'b0;
         pend_ff        <= 1'b0;
         wpend_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kvalid_ff      <= kvalid_in;
         list_length_ff <= list_length_in;
         load_ptr_ff    <= load_ptr_in;
         pass_ff        <= pass_in;
         pend_ff        <= pend_in;
         wpend_ff       <= wpend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      start_ff     <= start_in;
      issue_ff     <= issue_in;
      pidx_ff      <= pidx_in;
      sh_ff        <= sh_in;
      wdst_ff      <= wdst_in;
      hold_ff      <= hold_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (km_we) begin
         killer_mem[km_waddr] <= km_wdata;
      end
      if (km_re) begin
         krd_ff       <= killer_mem[km_raddr];
         krd_valid_ff <= kvalid_ff[km_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (lm_we) begin
         list_mem[lm_waddr] <= lm_wdata;
      end
      if (lm_re) begin
         lrd_ff <= list_mem[lm_raddr];
      end
   end

   always_comb begin
      rsp_valid     = rsp_valid_ff;
      rsp_out_move  = lrd_ff[2*W-1:W];
      rsp_out_score = lrd_ff[W-1:0];
      rsp_out_index = rsp_index_ff;
      rsp_out_last  = rsp_last_ff;
   end

endmodule

### rtl/killer_move_table_reorder.sv
`timescale 1ns / 1ps
// Killer move table with move list reordering. A request is taken when start is high
// and busy is low; requests wait in a two-entry queue, and busy is high only while that
// queue is full. Load and clear finish in the execution unit as they leave the queue;
// a save reads the memories and then updates the killer entry in its SAVE state.
// A reorder works through the list memory one entry per cycle: each of the two killer
// searches scans from the start position, a found killer is rotated to that position,
// and the list is then streamed out from position zero; with an out-of-range depth the
// searches are skipped. Results come one per cycle with rsp_valid high for a single
// cycle each; the receiver cannot stall them and must take every one.
`include "killer_move_table_reorder_macros.svh"
module killer_move_table_reorder #(
   parameter int DEPTH_LEVELS = 64,
   parameter int LIST_SIZE    = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [kmtr_pkg::ACTION_W-1:0]       req_action,
   input  logic [kmtr_pkg::DEPTH_W-1:0]        req_depth,
   input  logic [kmtr_pkg::POS_W-1:0]          req_position,
   input  logic signed [kmtr_pkg::WORD_W-1:0]  req_move_code,
   input  logic signed [kmtr_pkg::WORD_W-1:0]  req_score,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic signed [kmtr_pkg::WORD_W-1:0]  rsp_out_move,
   output logic signed [kmtr_pkg::WORD_W-1:0]  rsp_out_score,
   output logic [kmtr_pkg::POS_W-1:0]          rsp_out_index,
   output logic                                rsp_out_last
);

   logic              push;
   logic              queue_full;
   logic              head_valid;
   logic              head_pop;
   kmtr_pkg::cmd_type push_cmd;
   kmtr_pkg::cmd_type head_cmd;

   assign busy = queue_full;

   kmtr_front #(
      .DEPTH_LEVELS (DEPTH_LEVELS)
   ) u_front (
      .start         (start),
      .queue_full    (queue_full),
      .req_action    (req_action),
      .req_depth     (req_depth),
      .req_position  (req_position),
      .req_move_code (req_move_code),
      .req_score     (req_score),
      .req_last      (req_last),
      .push          (push),
      .cmd           (push_cmd)
   );

   kmtr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (head_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   kmtr_back #(
      .DEPTH_LEVELS (DEPTH_LEVELS),
      .LIST_SIZE    (LIST_SIZE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (head_valid),
      .cmd           (head_cmd),
      .cmd_pop       (head_pop),
      .rsp_valid     (rsp_valid),
      .rsp_out_move  (rsp_out_move),
      .rsp_out_score (rsp_out_score),
      .rsp_out_index (rsp_out_index),
      .rsp_out_last  (rsp_out_last)
   );

   `KMTR_ASSERT_SAME(a_stream_starts_at_zero, clock, reset, $rose(rsp_valid), rsp_out_index == '0, "result stream did not start at list position zero")
   `KMTR_ASSERT_NEXT(a_stream_is_contiguous, clock, reset, rsp_valid && !rsp_out_last, rsp_valid && (rsp_out_index == $past(rsp_out_index) + 6'd1), "result stream broke before its last entry")
   `KMTR_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_out_last, !rsp_valid, "result strobe directly followed the last entry")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
class killer_scoreboard #(int DEPTH_LEVELS = 64, int LIST_SIZE = 64);
   typedef struct {
      logic [31:0] move_code;
      logic [31:0] score;
      logic [5:0]  index;
      logic        last;
   } list_entry;

   logic [31:0] killer_first [DEPTH_LEVELS];
   logic [31:0] killer_second [DEPTH_LEVELS];
   logic [31:0] list_moves [LIST_SIZE];
   logic [31:0] list_scores [LIST_SIZE];
   int list_length;
   int load_pointer;
   list_entry emitted_entries [$];
   int failures;

   function new();
      for (int i = 0; i < DEPTH_LEVELS; i++) begin
         killer_first[i] = '0;
         killer_second[i] = '0;
      end
      for (int i = 0; i < LIST_SIZE; i++) begin
         list_moves[i] = '0;
         list_scores[i] = '0;
      end
      list_length = 0;
      load_pointer = 0;
      failures = 0;
   endfunction

   function int pending();
      return emitted_entries.size();
   endfunction

   function void flag(string reason);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $time, reason);
      end
   endfunction

   function void rotate_to_front(int start_index, logic [31:0] killer);
      int found;
      logic [31:0] held_move;
      logic [31:0] held_score;
      found = start_index;
      while (found < list_length && list_moves[found] != killer) begin
         found++;
      end
      if (found >= list_length) begin
         return;
      end
      held_move = list_moves[found];
      held_score = list_scores[found];
      for (int i = found; i > start_index; i--) begin
         list_moves[i] = list_moves[i - 1];
         list_scores[i] = list_scores[i - 1];
      end
      list_moves[start_index] = held_move;
      list_scores[start_index] = held_score;
   endfunction

   function void note_request(kmtr_pkg::action_type action, logic [5:0] depth,
                              logic [5:0] position, logic [31:0] move_code,
                              logic [31:0] score, logic last);
      list_entry entry;
      case (action)
         kmtr_pkg::ACT_SAVE: begin
            if (int'(depth) < DEPTH_LEVELS && int'(position) < list_length) begin
               if (killer_first[depth] != list_moves[position]) begin
                  killer_second[depth] = killer_first[depth];
                  killer_first[depth] = list_moves[position];
               end
            end
         end
         kmtr_pkg::ACT_LOAD: begin
            if (load_pointer < LIST_SIZE) begin
               list_moves[load_pointer] = move_code;
               list_scores[load_pointer] = score;
               load_pointer++;
            end
            if (last) begin
               list_length = load_pointer;
               load_pointer = 0;
            end
         end
         kmtr_pkg::ACT_CLEAR: begin
            for (int i = 0; i < DEPTH_LEVELS; i++) begin
               killer_first[i] = '0;
               killer_second[i] = '0;
            end
         end
         default: begin
            if (int'(depth) < DEPTH_LEVELS) begin
               rotate_to_front(int'(position), killer_first[depth]);
               rotate_to_front(int'(position) + 1, killer_second[depth]);
            end
            for (int k = 0; k < list_length; k++) begin
               entry.move_code = list_moves[k];
               entry.score = list_scores[k];
               entry.index = k[5:0];
               entry.last = (k + 1 == list_length);
               emitted_entries.push_back(entry);
            end
         end
      endcase
   endfunction

   function void check_result(logic [31:0] move_code, logic [31:0] score,
                              logic [5:0] index, logic last);
      list_entry expected;
      if (emitted_entries.size() == 0) begin
         flag($sformatf("unexpected result: move %h score %h index %0d last %b",
                        move_code, score, index, last));
         return;
      end
      expected = emitted_entries.pop_front();
      if (move_code !== expected.move_code || score !== expected.score ||
          index !== expected.index || last !== expected.last) begin
         flag($sformatf({"mismatch: expected move %h score %h index %0d last %b, ",
                         "got move %h score %h index %0d last %b"},
                        expected.move_code, expected.score, expected.index,
                        expected.last, move_code, score, index, last));
      end
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 300;
   localparam int ITEM_COUNT = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [kmtr_pkg::ACTION_W-1:0] req_action = '0;
   logic [kmtr_pkg::DEPTH_W-1:0] req_depth = '0;
   logic [kmtr_pkg::POS_W-1:0] req_position = '0;
   logic signed [kmtr_pkg::WORD_W-1:0] req_move_code = '0;
   logic signed [kmtr_pkg::WORD_W-1:0] req_score = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic signed [kmtr_pkg::WORD_W-1:0] rsp_out_move;
   logic signed [kmtr_pkg::WORD_W-1:0] rsp_out_score;
   logic [kmtr_pkg::POS_W-1:0] rsp_out_index;
   logic rsp_out_last;

   killer_scoreboard sb;
   int cycle_count = 0;
   int burst_left = 0;
   int items_sent = 0;
   logic [kmtr_pkg::WORD_W-1:0] move_pool [4] = '{32'h0000_0000, 32'h8000_0000,
                                                  32'h7fff_ffff, 32'h1234_5678};

   killer_move_table_reorder u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_depth(req_depth),
      .req_position(req_position),
      .req_move_code(req_move_code),
      .req_score(req_score),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_out_move(rsp_out_move),
      .rsp_out_score(rsp_out_score),
      .rsp_out_index(rsp_out_index),
      .rsp_out_last(rsp_out_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_out_move, rsp_out_score, rsp_out_index, rsp_out_last);
      end
   end

   function automatic logic [kmtr_pkg::WORD_W-1:0] pick_move();
      return $urandom_range(0, 1) ? move_pool[$urandom_range(0, 3)] : $urandom();
   endfunction

   function automatic logic [kmtr_pkg::DEPTH_W-1:0] pick_depth();
      return ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, 3));
   endfunction

   function automatic logic [kmtr_pkg::POS_W-1:0] pick_position(int stored);
      return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, stored - 1));
   endfunction

   task automatic send_request(kmtr_pkg::action_type action,
                               logic [kmtr_pkg::DEPTH_W-1:0] depth,
                               logic [kmtr_pkg::POS_W-1:0] position,
                               logic [kmtr_pkg::WORD_W-1:0] move_code,
                               logic [kmtr_pkg::WORD_W-1:0] score, logic last);
      int gap;
      start <= 1'b1;
      req_action <= action;
      req_depth <= depth;
      req_position <= position;
      req_move_code <= move_code;
      req_score <= score;
      req_last <= last;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_request(action, depth, position, move_code, score, last);
      items_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic load_list(int count, bit close);
      for (int i = 0; i < count; i++) begin
         send_request(kmtr_pkg::ACT_LOAD, 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), pick_move(), $urandom(),
                      close && (i == count - 1));
      end
   endtask

   task automatic play_sequence(int count);
      int stored;
      stored = (count > 64) ? 64 : count;
      load_list(count, 1'b1);
      repeat ($urandom_range(0, 4)) begin
         send_request(kmtr_pkg::ACT_SAVE, pick_depth(), pick_position(stored),
                      $urandom(), $urandom(), 1'($urandom_range(0, 1)));
      end
      send_request(kmtr_pkg::ACT_REORDER, pick_depth(), pick_position(stored),
                   $urandom(), $urandom(), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(kmtr_pkg::ACT_REORDER, 6'd0, 6'd0, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_LOAD, 6'd63, 6'd63, 32'h0000_0000, 32'h8000_0000, 1'b0);
      send_request(kmtr_pkg::ACT_LOAD, 6'd0, 6'd0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      send_request(kmtr_pkg::ACT_LOAD, 6'h2a, 6'h15, 32'h8000_0000, 32'hffff_ffff, 1'b0);
      send_request(kmtr_pkg::ACT_LOAD, 6'h15, 6'h2a, 32'hffff_ffff, 32'h0000_0000, 1'b1);
      send_request(kmtr_pkg::ACT_REORDER, 6'd5, 6'd0, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      send_request(kmtr_pkg::ACT_SAVE, 6'd63, 6'd3, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_SAVE, 6'd63, 6'd1, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_SAVE, 6'd63, 6'd1, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_SAVE, 6'd63, 6'd63, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_REORDER, 6'd63, 6'd0, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_REORDER, 6'd63, 6'd63, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_REORDER, 6'd63, 6'd3, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_CLEAR, 6'd63, 6'd63, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      send_request(kmtr_pkg::ACT_REORDER, 6'd63, 6'd1, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_LOAD, 6'd1, 6'd2, 32'h1234_5678, 32'h5555_5555, 1'b0);
      send_request(kmtr_pkg::ACT_LOAD, 6'd3, 6'd4, 32'h0000_0000, 32'haaaa_aaaa, 1'b0);
      send_request(kmtr_pkg::ACT_REORDER, 6'd0, 6'd0, 32'h0, 32'h0, 1'b0);
      send_request(kmtr_pkg::ACT_LOAD, 6'd5, 6'd6, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
      send_request(kmtr_pkg::ACT_REORDER, 6'd0, 6'd0, 32'h0, 32'h0, 1'b0);
      wait_drained();

      play_sequence(66);
      while (items_sent < ITEM_COUNT) begin
         case ($urandom_range(0, 9))
            0: send_request(kmtr_pkg::action_type'($urandom_range(0, 3)),
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                            $urandom(), $urandom(), 1'($urandom_range(0, 1)));
            1: send_request(kmtr_pkg::ACT_CLEAR, 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)), $urandom(), $urandom(),
                            1'($urandom_range(0, 1)));
            2: begin
               load_list($urandom_range(1, 3), 1'b0);
               send_request(kmtr_pkg::ACT_REORDER, pick_depth(), 6'($urandom_range(0, 63)),
                            $urandom(), $urandom(), 1'($urandom_range(0, 1)));
            end
            default: play_sequence(($urandom_range(0, 15) == 0) ? 64 : $urandom_range(1, 12));
         endcase
         if ($urandom_range(0, 15) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/kmtr_pkg.sv
rtl/kmtr_front.sv
rtl/kmtr_queue.sv
rtl/kmtr_back.sv
rtl/killer_move_table_reorder.sv
sim/testbench.sv
